// ===== rtl/tlge_pkg.sv =====
`timescale 1ns / 1ps

package tlge_pkg;

  // field widths of the command and result beats
  localparam int CMD_W    = 3;
  localparam int IN_ROW_W = 8;
  localparam int IN_COL_W = 9;

  // width used to range check a cell address against the grid size
  localparam int RANGE_W = 11;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WRITE       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ        = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STEP        = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ROLL_LO_COL = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ROLL_HI_COL = 3'd5;
  localparam logic [CMD_W-1:0] CMD_ROLL_LO_ROW = 3'd6;
  localparam logic [CMD_W-1:0] CMD_ROLL_HI_ROW = 3'd7;

  typedef logic [3:0] nbr_count_t;

endpackage

// ===== rtl/tlge_ram.sv =====
`timescale 1ns / 1ps

module tlge_ram #(
  parameter int WIDTH = 320,
  parameter int DEPTH = 240
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/toroidal_life_grid_engine_unit.sv =====
`timescale 1ns / 1ps

// channel   | ports                                        | handshake
// ----------+----------------------------------------------+--------------------------------
// command   | in_command, in_row, in_col, in_cell_in       | taken when start & !busy
// result    | out_cell_out, out_done_command               | out_valid, one cycle, no stall
//
// the grid lives in one ram, one row per word; a shared neighbor counter walks
// one cell per cycle through each row of a generation. rolls and clear sweep
// the rows once; write and read touch one row word. the result beat is
// registered and shows in the cycle after the last work cycle.
// after reset a clearing pass writes every row once, with busy high meanwhile.
// the receiver cannot stall; busy is high for the whole command.

module toroidal_life_grid_engine_unit import tlge_pkg::*; #(
  parameter int GRID_ROWS = 240,
  parameter int GRID_COLS = 320
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [IN_ROW_W-1:0] in_row,
  input  logic [IN_COL_W-1:0] in_col,
  input  logic                in_cell_in,
  output logic                out_valid,
  output logic                out_cell_out,
  output logic [CMD_W-1:0]    out_done_command
);

  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int COL_W = $clog2(GRID_COLS);

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID_COLS - 1);

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CELL  = 4'd1;  // row word back from ram
  localparam logic [3:0] ST_SKIP  = 4'd2;  // address off the grid
  localparam logic [3:0] ST_LD0   = 4'd3;  // last row arrives
  localparam logic [3:0] ST_LD1   = 4'd4;  // row 0 arrives
  localparam logic [3:0] ST_LD2   = 4'd5;  // row 1 arrives
  localparam logic [3:0] ST_GEN   = 4'd6;  // one cell per cycle
  localparam logic [3:0] ST_WB    = 4'd7;  // write back a finished row
  localparam logic [3:0] ST_FETCH = 4'd8;  // next lower row arrives
  localparam logic [3:0] ST_CLR   = 4'd9;  // zero one row per cycle

  typedef logic [GRID_COLS-1:0] row_vec_t;

  // control state
  logic [3:0]       state_r, state_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic             boot_r, boot_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload
  logic             cell_r, cell_nxt;
  logic             out_cell_r, out_cell_nxt;
  logic [CMD_W-1:0] out_cmd_r, out_cmd_nxt;
  row_vec_t         up_r, up_nxt;     // old row above
  row_vec_t         mid_r, mid_nxt;   // old row being rewritten
  row_vec_t         dn_r, dn_nxt;     // old row below
  row_vec_t         row0_r, row0_nxt; // old row 0, kept for the wrap at the bottom
  row_vec_t         new_r, new_nxt;   // generation result being built

  // ram port
  logic             wr_en;
  logic [ROW_W-1:0] wr_addr;
  row_vec_t         wr_data;
  logic [ROW_W-1:0] rd_addr;
  row_vec_t         rd_data;

  // shared neighbor counter
  logic [COL_W-1:0] col_lo, col_hi;
  nbr_count_t       nbr_cnt;
  logic             life_bit;

  logic             accept;
  logic             addr_ok;
  row_vec_t         patched_row;
  row_vec_t         sweep_row;

  tlge_ram #(
    .WIDTH (GRID_COLS),
    .DEPTH (GRID_ROWS)
  ) u_grid_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign addr_ok = (RANGE_W'(in_row) < RANGE_W'(GRID_ROWS)) &&
                   (RANGE_W'(in_col) < RANGE_W'(GRID_COLS));

  // wrapped column neighbors
  assign col_lo = (col_r == '0) ? LAST_COL : col_r - COL_W'(1);
  assign col_hi = (col_r == LAST_COL) ? '0 : col_r + COL_W'(1);

  assign nbr_cnt = nbr_count_t'(up_r[col_lo]) + nbr_count_t'(up_r[col_r]) +
                   nbr_count_t'(up_r[col_hi]) + nbr_count_t'(mid_r[col_lo]) +
                   nbr_count_t'(mid_r[col_hi]) + nbr_count_t'(dn_r[col_lo]) +
                   nbr_count_t'(dn_r[col_r]) + nbr_count_t'(dn_r[col_hi]);

  // b3/s23
  assign life_bit = (nbr_cnt == nbr_count_t'(3)) ||
                    ((nbr_cnt == nbr_count_t'(2)) && mid_r[col_r]);

  // single cell write merged into its row word
  always_comb begin
    patched_row        = rd_data;
    patched_row[col_r] = cell_r;
  end

  // row word written back at the end of each row of a sweep
  always_comb begin
    case (cmd_r)
      CMD_ROLL_LO_COL: sweep_row = {mid_r[0], mid_r[GRID_COLS-1:1]};
      CMD_ROLL_HI_COL: sweep_row = {mid_r[GRID_COLS-2:0], mid_r[GRID_COLS-1]};
      CMD_ROLL_LO_ROW: sweep_row = dn_r;
      CMD_ROLL_HI_ROW: sweep_row = up_r;
      default:         sweep_row = new_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cmd_nxt       = cmd_r;
    boot_nxt      = boot_r;
    cell_nxt      = cell_r;
    up_nxt        = up_r;
    mid_nxt       = mid_r;
    dn_nxt        = dn_r;
    row0_nxt      = row0_r;
    new_nxt       = new_r;
    out_valid_nxt = 1'b0;
    out_cell_nxt  = 1'b0;
    out_cmd_nxt   = cmd_r;
    wr_en         = 1'b0;
    wr_addr       = row_r;
    wr_data       = '0;
    rd_addr       = row_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_command;
          cell_nxt = in_cell_in;
          col_nxt  = COL_W'(in_col);
          row_nxt  = '0;
          case (in_command)
            CMD_WRITE, CMD_READ: begin
              // cell address kept in row_r and col_r
              row_nxt   = ROW_W'(in_row);
              rd_addr   = ROW_W'(in_row);
              state_nxt = addr_ok ? ST_CELL : ST_SKIP;
            end
            CMD_CLEAR: begin
              state_nxt = ST_CLR;
            end
            default: begin
              // generation and rolls start by loading the row window
              rd_addr   = LAST_ROW;
              state_nxt = ST_LD0;
            end
          endcase
        end
      end

      ST_CELL: begin
        if (cmd_r == CMD_WRITE) begin
          wr_en   = 1'b1;
          wr_addr = row_r;
          wr_data = patched_row;
        end
        out_valid_nxt = 1'b1;
        out_cell_nxt  = (cmd_r == CMD_READ) ? rd_data[col_r] : 1'b0;
        state_nxt     = ST_IDLE;
      end

      ST_SKIP: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      ST_LD0: begin
        up_nxt    = rd_data;
        rd_addr   = '0;
        state_nxt = ST_LD1;
      end

      ST_LD1: begin
        mid_nxt   = rd_data;
        row0_nxt  = rd_data;
        rd_addr   = ROW_W'(1);
        state_nxt = ST_LD2;
      end

      ST_LD2: begin
        dn_nxt    = rd_data;
        row_nxt   = '0;
        col_nxt   = '0;
        state_nxt = (cmd_r == CMD_STEP) ? ST_GEN : ST_WB;
      end

      ST_GEN: begin
        new_nxt[col_r] = life_bit;
        if (col_r == LAST_COL) begin
          state_nxt = ST_WB;
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end

      ST_WB: begin
        wr_en   = 1'b1;
        wr_addr = row_r;
        wr_data = sweep_row;
        // row r+2 is still untouched; past the bottom it is replaced by row 0
        rd_addr = row_r + ROW_W'(2);
        up_nxt  = mid_r;
        mid_nxt = dn_r;
        if (row_r == LAST_ROW) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          row_nxt   = row_r + ROW_W'(1);
          state_nxt = ST_FETCH;
        end
      end

      ST_FETCH: begin
        dn_nxt    = (row_r == LAST_ROW) ? row0_r : rd_data;
        col_nxt   = '0;
        state_nxt = (cmd_r == CMD_STEP) ? ST_GEN : ST_WB;
      end

      ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = row_r;
        wr_data = '0;
        if (row_r == LAST_ROW) begin
          // the pass after reset reports nothing
          out_valid_nxt = !boot_r;
          boot_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      row_r       <= '0;
      col_r       <= '0;
      cmd_r       <= CMD_CLEAR;
      boot_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cmd_r       <= cmd_nxt;
      boot_r      <= boot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_r     <= cell_nxt;
    out_cell_r <= out_cell_nxt;
    out_cmd_r  <= out_cmd_nxt;
    up_r       <= up_nxt;
    mid_r      <= mid_nxt;
    dn_r       <= dn_nxt;
    row0_r     <= row0_nxt;
    new_r      <= new_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_cell_out     = out_cell_r;
  assign out_done_command = out_cmd_r;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// self-checking bench for the toroidal life grid engine
// a directed table walks the corners, out-of-grid addresses, every roll, clear
// and a blinker that straddles the corner wrap; then random episodes write
// and read a small window of cells around a center, mixed with rolls, a few
// generations and some noise; every result beat is checked against a
// bit-level model of the grid kept here, or for typed table rows against their hand-written value

module tb;
  import tlge_pkg::*;

  localparam int GRID_ROWS = 240;
  localparam int GRID_COLS = 320;
  localparam int RANDOM_ITEMS = 100;
  // a generation sweeps the whole grid, so they are rationed
  localparam int MAX_RANDOM_GENERATIONS = 6;

  typedef logic [GRID_COLS-1:0] grid_row_t;

  // one expected result beat
  typedef struct packed {
    logic             alive;
    logic [CMD_W-1:0] command;
  } grid_answer_t;

  // one row of the directed table; typed rows carry a hand-written cell value
  typedef struct {
    logic [CMD_W-1:0]    command;
    logic [IN_ROW_W-1:0] row;
    logic [IN_COL_W-1:0] col;
    logic                cell_in;
    bit                  typed;
    logic                typed_alive;
  } grid_stim_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    in_command = CMD_WRITE;
  logic [IN_ROW_W-1:0] in_row = '0;
  logic [IN_COL_W-1:0] in_col = '0;
  logic                in_cell_in = 1'b0;
  logic                out_valid;
  logic                out_cell_out;
  logic [CMD_W-1:0]    out_done_command;

  // model of the grid: bit c of life_rows[r] is the cell at row r, column c
  grid_row_t    life_rows [GRID_ROWS];
  grid_answer_t grid_answers_q [$];
  grid_stim_t   directed_q [$];
  int           fail_count = 0;
  int           generations_left = MAX_RANDOM_GENERATIONS;

  toroidal_life_grid_engine_unit #(
    .GRID_ROWS(GRID_ROWS),
    .GRID_COLS(GRID_COLS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_cell_in       (in_cell_in),
    .out_valid        (out_valid),
    .out_cell_out     (out_cell_out),
    .out_done_command (out_done_command)
  );

  always #5 clk = ~clk;

  // a hung engine or a lost result beat ends here
  initial begin
    #40ms;
    $display("toroidal_life_grid_engine_unit test failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // applies one accepted command to the grid model, returns the cell read
  function automatic logic apply_life_command(input logic [CMD_W-1:0] cmd,
                                              input logic [IN_ROW_W-1:0] row,
                                              input logic [IN_COL_W-1:0] col,
                                              input logic cell_in);
    grid_row_t prev [GRID_ROWS];
    logic      on_grid;
    logic      alive;
    int        ru, rd, cl, cr, n;
    on_grid = (row < GRID_ROWS) && (col < GRID_COLS);
    alive = 1'b0;
    prev = life_rows;
    case (cmd)
      CMD_WRITE: begin
        if (on_grid) life_rows[row][col] = cell_in;
      end
      CMD_READ: begin
        if (on_grid) alive = life_rows[row][col];
      end
      CMD_STEP: begin
        // b3/s23 over the wrapped neighborhood of the old grid
        for (int r = 0; r < GRID_ROWS; r++) begin
          ru = (r == 0) ? GRID_ROWS - 1 : r - 1;
          rd = (r == GRID_ROWS - 1) ? 0 : r + 1;
          for (int c = 0; c < GRID_COLS; c++) begin
            cl = (c == 0) ? GRID_COLS - 1 : c - 1;
            cr = (c == GRID_COLS - 1) ? 0 : c + 1;
            n = int'(prev[ru][cl]) + int'(prev[ru][c]) + int'(prev[ru][cr])
              + int'(prev[r][cl]) + int'(prev[r][cr])
              + int'(prev[rd][cl]) + int'(prev[rd][c]) + int'(prev[rd][cr]);
            if (n == 3) life_rows[r][c] = 1'b1;
            else if (n != 2) life_rows[r][c] = 1'b0;
          end
        end
      end
      CMD_CLEAR: begin
        for (int r = 0; r < GRID_ROWS; r++) life_rows[r] = '0;
      end
      CMD_ROLL_LO_COL: begin
        // each cell takes the value of its right-hand neighbor
        for (int r = 0; r < GRID_ROWS; r++)
          life_rows[r] = {prev[r][0], prev[r][GRID_COLS-1:1]};
      end
      CMD_ROLL_HI_COL: begin
        for (int r = 0; r < GRID_ROWS; r++)
          life_rows[r] = {prev[r][GRID_COLS-2:0], prev[r][GRID_COLS-1]};
      end
      CMD_ROLL_LO_ROW: begin
        for (int r = 0; r < GRID_ROWS; r++)
          life_rows[r] = prev[(r + 1) % GRID_ROWS];
      end
      default: begin
        for (int r = 0; r < GRID_ROWS; r++)
          life_rows[r] = prev[(r + GRID_ROWS - 1) % GRID_ROWS];
      end
    endcase
    return alive;
  endfunction

  // drives one command beat, holds it until the engine takes it, then
  // queues the expected result; start stays high across back-to-back beats
  task automatic issue_command(input logic [CMD_W-1:0] cmd,
                               input logic [IN_ROW_W-1:0] row,
                               input logic [IN_COL_W-1:0] col,
                               input logic cell_in,
                               input int idle_pct,
                               input bit typed,
                               input logic typed_alive);
    int           gap;
    grid_answer_t ans;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_command <= cmd;
    in_row     <= row;
    in_col     <= col;
    in_cell_in <= cell_in;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    // accepted at this edge
    ans.alive = apply_life_command(cmd, row, col, cell_in);
    if (typed) ans.alive = typed_alive;
    ans.command = cmd;
    grid_answers_q.push_back(ans);
  endtask

  // result beats cannot be held off, so every strobe is checked as it comes
  always @(posedge clk) begin : check_results
    grid_answer_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (grid_answers_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending, command %0d",
                                  out_done_command));
      end else begin
        want = grid_answers_q.pop_front();
        if (out_cell_out !== want.alive)
          report_mismatch($sformatf("cell_out %b, want %b (command %0d)",
                                    out_cell_out, want.alive, want.command));
        if (out_done_command !== want.command)
          report_mismatch($sformatf("done_command %0d, want %0d",
                                    out_done_command, want.command));
      end
    end
  end

  initial begin : stimulus
    logic [CMD_W-1:0]    cmd;
    logic [IN_ROW_W-1:0] row;
    logic [IN_COL_W-1:0] col;
    logic                cell_in;
    int                  pick, idle_pct, win_row, win_col;
    grid_stim_t          s;

    for (int r = 0; r < GRID_ROWS; r++) life_rows[r] = '0;

    // corners, out-of-grid addresses on both axes, ignored fields
    directed_q.push_back('{CMD_READ,  8'd0,   9'd0,   1'b1, 1'b1, 1'b0});
    directed_q.push_back('{CMD_READ,  8'd239, 9'd319, 1'b0, 1'b1, 1'b0});
    directed_q.push_back('{CMD_WRITE, 8'd239, 9'd319, 1'b1, 1'b1, 1'b0});
    directed_q.push_back('{CMD_READ,  8'd239, 9'd319, 1'b0, 1'b1, 1'b1});
    directed_q.push_back('{CMD_WRITE, 8'd0,   9'd0,   1'b1, 1'b1, 1'b0});
    directed_q.push_back('{CMD_WRITE, 8'd240, 9'd0,   1'b1, 1'b1, 1'b0});
    directed_q.push_back('{CMD_READ,  8'd240, 9'd0,   1'b1, 1'b1, 1'b0});
    directed_q.push_back('{CMD_WRITE, 8'd0,   9'd320, 1'b1, 1'b1, 1'b0});
    directed_q.push_back('{CMD_READ,  8'd0,   9'd320, 1'b0, 1'b1, 1'b0});
    directed_q.push_back('{CMD_WRITE, 8'd255, 9'd511, 1'b1, 1'b1, 1'b0});
    directed_q.push_back('{CMD_READ,  8'd255, 9'd511, 1'b1, 1'b1, 1'b0});
    // every roll, with the live corner cells wrapping around the edges
    directed_q.push_back('{CMD_ROLL_LO_COL, 8'd255, 9'd511, 1'b1, 1'b0, 1'b0});
    directed_q.push_back('{CMD_READ,        8'd239, 9'd318, 1'b0, 1'b0, 1'b0});
    directed_q.push_back('{CMD_ROLL_HI_ROW, 8'd0,   9'd0,   1'b0, 1'b0, 1'b0});
    directed_q.push_back('{CMD_READ,        8'd0,   9'd318, 1'b0, 1'b0, 1'b0});
    directed_q.push_back('{CMD_ROLL_HI_COL, 8'd17,  9'd400, 1'b1, 1'b0, 1'b0});
    directed_q.push_back('{CMD_ROLL_LO_ROW, 8'd250, 9'd3,   1'b0, 1'b0, 1'b0});
    directed_q.push_back('{CMD_READ,        8'd0,   9'd0,   1'b0, 1'b0, 1'b0});
    directed_q.push_back('{CMD_CLEAR,       8'd171, 9'd300, 1'b1, 1'b1, 1'b0});
    directed_q.push_back('{CMD_READ,        8'd0,   9'd0,   1'b0, 1'b1, 1'b0});
    // blinker across the column seam, then one generation flips it upright
    directed_q.push_back('{CMD_WRITE, 8'd0,   9'd319, 1'b1, 1'b0, 1'b0});
    directed_q.push_back('{CMD_WRITE, 8'd0,   9'd0,   1'b1, 1'b0, 1'b0});
    directed_q.push_back('{CMD_WRITE, 8'd0,   9'd1,   1'b1, 1'b0, 1'b0});
    directed_q.push_back('{CMD_STEP,  8'd99,  9'd77,  1'b1, 1'b0, 1'b0});
    directed_q.push_back('{CMD_READ,  8'd239, 9'd0,   1'b0, 1'b0, 1'b0});
    directed_q.push_back('{CMD_READ,  8'd0,   9'd1,   1'b1, 1'b0, 1'b0});
    directed_q.push_back('{CMD_READ,  8'd1,   9'd0,   1'b0, 1'b0, 1'b0});

    // synchronous reset, released while start is still low before the first beat;
    // the engine clears its grid after reset and holds busy meanwhile
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (directed_q[i]) begin
      s = directed_q[i];
      issue_command(s.command, s.row, s.col, s.cell_in, 0, s.typed, s.typed_alive);
    end

    // random episodes: writes and reads cluster in a 7x7 window so that
    // generations and rolls act on live patterns the reads can see
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 25 == 0) begin
        // the first window sits on the corner to keep the wrap busy
        win_row = (i == 0) ? 0 : int'($urandom_range(GRID_ROWS - 1));
        win_col = (i == 0) ? 0 : int'($urandom_range(GRID_COLS - 1));
      end
      // idle phases: none, heavy, light, then alternating bursts
      if (i < 25)      idle_pct = 0;
      else if (i < 50) idle_pct = 53;
      else if (i < 75) idle_pct = 23;
      else             idle_pct = ((i / 8) % 2 == 1) ? 53 : 0;

      pick    = int'($urandom_range(99));
      cmd     = CMD_READ;
      row     = IN_ROW_W'((win_row + int'($urandom_range(6)) - 3 + GRID_ROWS) % GRID_ROWS);
      col     = IN_COL_W'((win_col + int'($urandom_range(6)) - 3 + GRID_COLS) % GRID_COLS);
      cell_in = ($urandom_range(99) < 60);
      if (pick < 34) begin
        cmd = CMD_WRITE;
      end else if (pick < 64) begin
        cmd = CMD_READ;
      end else if (pick < 76) begin
        cmd = CMD_ROLL_LO_COL + CMD_W'($urandom_range(3));
        row = IN_ROW_W'($urandom);
        col = IN_COL_W'($urandom);
      end else if (pick < 81) begin
        if (generations_left > 0) begin
          cmd = CMD_STEP;
          generations_left--;
          row = IN_ROW_W'($urandom);
          col = IN_COL_W'($urandom);
        end
      end else if (pick < 83) begin
        cmd = CMD_CLEAR;
        row = IN_ROW_W'($urandom);
        col = IN_COL_W'($urandom);
      end else if (pick < 92) begin
        // off the grid on one axis or both
        cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
        case ($urandom_range(2))
          0: row = IN_ROW_W'($urandom_range(255, GRID_ROWS));
          1: col = IN_COL_W'($urandom_range(511, GRID_COLS));
          default: begin
            row = IN_ROW_W'($urandom_range(255, GRID_ROWS));
            col = IN_COL_W'($urandom_range(511, GRID_COLS));
          end
        endcase
      end else begin
        cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
        row = IN_ROW_W'($urandom_range(GRID_ROWS - 1));
        col = IN_COL_W'($urandom_range(GRID_COLS - 1));
      end
      issue_command(cmd, row, col, cell_in, idle_pct, 1'b0, 1'b0);
    end
    start <= 1'b0;

    // drain, then give a stray beat some time to show up
    while (grid_answers_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("toroidal_life_grid_engine_unit test passed");
    end else begin
      $display("toroidal_life_grid_engine_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tlge_pkg.sv
rtl/tlge_ram.sv
rtl/toroidal_life_grid_engine_unit.sv
tb/tb.sv
